@@ rtl/ssb_pkg.sv @@
`timescale 1ns / 1ps

package ssb_pkg;

    // Descriptor width used by the request and result types.
    localparam int DESC_BITS = 32;

    // Configuration register indexes.
    localparam logic CFG_SLOTS_IN_USE = 1'b0;
    localparam logic CFG_STRIDE       = 1'b1;

    // Widest configuration register.
    localparam int CFG_BITS = 5;

    // Request type codes; the unused code is handled as data.
    localparam logic [1:0] REQ_DATA      = 2'd0;
    localparam logic [1:0] REQ_HEARTBEAT = 2'd1;
    localparam logic [1:0] REQ_SHUTDOWN  = 2'd2;

    typedef struct packed {
        logic [1:0]           req_type;
        logic [DESC_BITS-1:0] descriptor;
    } t_in_req;

    typedef struct packed {
        logic [DESC_BITS-1:0] out_descriptor;
        logic                 last;
    } t_out_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_READ,
        ST_SCAN,
        ST_FLUSH
    } t_state;

endpackage

@@ rtl/stride_slot_shuffle_buffer.sv @@
`timescale 1ns / 1ps

// Stride slot shuffle buffer. Message descriptors are scattered over a ring of
// MAX_SLOTS slots: each data request steps a position by the configured stride,
// modulo the number of slots in use, and the descriptor already sitting in that
// slot (if any) is released before the new one takes its place. A heartbeat
// request releases every occupied slot in slot order, and a shutdown request is
// stored like data and then flushed like a heartbeat. The last result caused by
// a request carries last = 1; a request may cause no result at all. The block
// works on one request at a time and raises o_stall while it does. For a data
// request the step position, SUM_BITS wide (one more than the wider of
// clog2(MAX_SLOTS) and 4), is reduced by a remainder unit that retires one bit
// per cycle, followed by one read of the slot memory. A flush walks all
// MAX_SLOTS slots and reads each occupied slot through the single memory read
// port. The block also waits while the consumer holds i_stall high with a
// result pending. Occupancy is cleared by reset; the slot contents are not, and
// need not be, because a slot's contents are only used while it is marked
// occupied. Configuration must be written only while the block is idle; the
// block itself does not enforce this. A slot count of zero acts as one and a
// count above MAX_SLOTS acts as MAX_SLOTS.
module stride_slot_shuffle_buffer
    import ssb_pkg::*;
#(
    parameter int MAX_SLOTS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_BITS-1:0] i_cfg_wdata,
    input  logic                i_valid,
    output logic                o_stall,
    input  t_in_req             i_req,
    output logic                o_valid,
    input  logic                i_stall,
    output t_out_res            o_res
);

    localparam int POS_BITS = $clog2(MAX_SLOTS);
    localparam int CNT_BITS = $clog2(MAX_SLOTS + 1);
    localparam int SUM_BITS = ((POS_BITS > 4) ? POS_BITS : 4) + 1;

    // Configuration registers.
    logic [4:0] r_slots;
    logic [3:0] r_stride;

    // Sequencer and request state.
    t_state               r_state, n_state;
    logic [1:0]           r_req_type, n_req_type;
    logic [DESC_BITS-1:0] r_desc, n_desc;
    logic [POS_BITS-1:0]  r_idx, n_idx;
    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic [POS_BITS-1:0]  r_scan, n_scan;
    logic [MAX_SLOTS-1:0] r_full, n_full;
    logic                 r_out_valid, n_out_valid;
    t_out_res             r_out_res, n_out_res;

    // Shared remainder unit and slot memory hookup.
    logic                 mod_start;
    logic                 mod_done;
    logic [CNT_BITS-1:0]  mod_rem;
    logic [CNT_BITS-1:0]  active_n;
    logic [SUM_BITS-1:0]  step_sum;
    logic [POS_BITS-1:0]  rem_pos;
    logic                 ram_rd_en;
    logic [POS_BITS-1:0]  ram_rd_addr;
    logic                 ram_wr_en;
    logic [DESC_BITS-1:0] ram_rd_data;
    logic                 out_free;
    logic                 full_above;
    logic                 scan_end;

    // The slot count in effect, clamped to the range the ring supports.
    always_comb begin
        if (r_slots == 5'd0) begin
            active_n = CNT_BITS'(1);
        end else if (int'(r_slots) > MAX_SLOTS) begin
            active_n = CNT_BITS'(MAX_SLOTS);
        end else begin
            active_n = CNT_BITS'(r_slots);
        end
    end

    // The position is always below MAX_SLOTS, so (pos + stride) mod n equals
    // the sum of the two separate remainders taken mod n.
    assign step_sum = SUM_BITS'(r_pos) + SUM_BITS'(r_stride);
    assign rem_pos  = POS_BITS'(mod_rem);

    ssb_mod_unit #(
        .DVD_BITS (SUM_BITS),
        .DIV_BITS (CNT_BITS)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (mod_start),
        .i_dividend (step_sum),
        .i_divisor  (active_n),
        .o_done     (mod_done),
        .o_rem      (mod_rem)
    );

    ssb_slot_ram #(
        .DEPTH     (MAX_SLOTS),
        .ADDR_BITS (POS_BITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (r_desc),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // A flushed result is the last one when no occupied slot lies beyond it.
    always_comb begin
        full_above = 1'b0;
        for (int i = 0; i < MAX_SLOTS; i++) begin
            if (r_full[i] && (POS_BITS'(i) > r_scan)) begin
                full_above = 1'b1;
            end
        end
    end

    assign scan_end = (r_scan == POS_BITS'(MAX_SLOTS - 1));

    // The output register can take a new result when it is empty or when its
    // current result is being taken at this edge.
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state     = r_state;
        n_req_type  = r_req_type;
        n_desc      = r_desc;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_scan      = r_scan;
        n_full      = r_full;
        n_out_valid = r_out_valid;
        n_out_res   = r_out_res;
        mod_start   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_scan;
        ram_wr_en   = 1'b0;
        o_stall     = (r_state != ST_IDLE);

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_req_type = i_req.req_type;
                    n_desc     = i_req.descriptor;
                    if (i_req.req_type == REQ_HEARTBEAT) begin
                        n_scan  = '0;
                        n_state = ST_SCAN;
                    end else begin
                        mod_start = 1'b1;
                        n_state   = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (mod_done) begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = rem_pos;
                    n_idx       = rem_pos;
                    n_pos       = rem_pos;
                    n_state     = ST_READ;
                end
            end
            ST_READ: begin
                // An occupied slot must hand its old descriptor to the output
                // register before the new one overwrites it.
                if (!r_full[r_idx] || out_free) begin
                    if (r_full[r_idx]) begin
                        n_out_valid              = 1'b1;
                        n_out_res.out_descriptor = ram_rd_data;
                        n_out_res.last           = (r_req_type != REQ_SHUTDOWN);
                    end
                    ram_wr_en     = 1'b1;
                    n_full[r_idx] = 1'b1;
                    if (r_req_type == REQ_SHUTDOWN) begin
                        n_scan  = '0;
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_SCAN: begin
                if (r_full[r_scan]) begin
                    ram_rd_en = 1'b1;
                    n_state   = ST_FLUSH;
                end else if (scan_end) begin
                    n_state = ST_IDLE;
                end else begin
                    n_scan = r_scan + POS_BITS'(1);
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_res.out_descriptor = ram_rd_data;
                    n_out_res.last           = !full_above;
                    n_full[r_scan]           = 1'b0;
                    if (scan_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_scan  = r_scan + POS_BITS'(1);
                        n_state = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_full      <= '0;
            r_out_valid <= 1'b0;
            r_slots     <= 5'd16;
            r_stride    <= 4'd7;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_full      <= n_full;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOTS_IN_USE: r_slots  <= i_cfg_wdata[4:0];
                    CFG_STRIDE:       r_stride <= i_cfg_wdata[3:0];
                    default:          r_slots  <= r_slots;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_req_type <= n_req_type;
        r_desc     <= n_desc;
        r_idx      <= n_idx;
        r_scan     <= n_scan;
        r_out_res  <= n_out_res;
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out_res;

endmodule

@@ rtl/ssb_mod_unit.sv @@
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle.
module ssb_mod_unit #(
    parameter int DVD_BITS = 5,
    parameter int DIV_BITS = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DVD_BITS-1:0] i_dividend,
    input  logic [DIV_BITS-1:0] i_divisor,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_rem
);

    localparam int CNT_BITS = $clog2(DVD_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DVD_BITS-1:0] r_dvd;
    logic [DIV_BITS-1:0] r_div;
    logic [DIV_BITS-1:0] r_rem;
    logic [DIV_BITS:0]   trial;
    logic [DIV_BITS-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[DVD_BITS-1]};
        if (trial >= {1'b0, r_div}) begin
            n_rem = DIV_BITS'(trial - {1'b0, r_div});
        end else begin
            n_rem = trial[DIV_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(DVD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

@@ rtl/ssb_slot_ram.sv @@
`timescale 1ns / 1ps

module ssb_slot_ram
    import ssb_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = 4
) (
    input  logic                 i_clk,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [DESC_BITS-1:0] i_wr_data,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [DESC_BITS-1:0] o_rd_data
);

    logic [DESC_BITS-1:0] r_mem [DEPTH];
    logic [DESC_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/ssb_checker.sv @@
`timescale 1ns / 1ps

module ssb_checker
    import ssb_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_cfg_we,
    input logic                i_cfg_idx,
    input logic [CFG_BITS-1:0] i_cfg_wdata,
    input logic                i_valid,
    input logic                o_stall,
    input t_in_req             i_req,
    input logic                o_valid,
    input logic                i_stall,
    input t_out_res            o_res
);

    // Reset empties the output register.
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result still offered after reset");

    // A result waiting on the consumer stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_res)))
        else $error("stalled result changed or vanished");

    // Every accepted request makes the block busy in the cycle after it is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("block idle right after taking a request");

    // Results are only produced while a request is being worked on.
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(o_stall))
        else $error("result appeared with no request in progress");

endmodule

bind stride_slot_shuffle_buffer ssb_checker u_ssb_checker (.*);
